### hw/rtl/ndhf_pkg.sv
// Shared types, sizes and helpers for the near-duplicate hash filter.
// No dependencies; imported by near_duplicate_hash_filter_top.
package ndhf_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam int ID_W    = 16;
    localparam int FP_W    = 64;
    localparam int SIZE_W  = 32;
    localparam int LIMIT_W = 7;
    localparam int SLOT_W  = 8;
    localparam int BYTES   = FP_W / 8;
    localparam int BC_W    = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd3;

    typedef enum logic [1:0] {
        OUT_STORED   = 2'd0,
        OUT_DROPPED  = 2'd1,
        OUT_REPLACED = 2'd2,
        OUT_FULL     = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [FP_W-1:0]   hash;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // Ones in one byte.
    function automatic logic [BC_W-1:0] byte_ones(input logic [7:0] b);
        logic [BC_W-1:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + BC_W'(b[k]);
        end
        return n;
    endfunction

    // Low slot bits of a table index, zero-extended when the index is narrow.
    function automatic logic [SLOT_W-1:0] to_slot(input logic [AW-1:0] idx);
        logic [AW+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

endpackage

### hw/rtl/near_duplicate_hash_filter_top.sv
// A new item is accepted only in the idle state, after the previous item's result has been
// loaded into the output register. The scan reads the table through the single read port,
// one entry per cycle, and stops at the first match.
// Reset (i_rst_n low, synchronous): table empty, distance_limit 3, no result pending.
// Table contents are not cleared; only entries below the fill count are ever read.
// Top level of the near-duplicate hash filter; depends on ndhf_pkg.
module near_duplicate_hash_filter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ndhf_pkg::LIMIT_W-1:0] i_distance_limit,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ndhf_pkg::ID_W-1:0]    i_item_id,
    input  logic [ndhf_pkg::FP_W-1:0]    i_fingerprint,
    input  logic [ndhf_pkg::SIZE_W-1:0]  i_file_size,
    // result items
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_outcome,
    output logic [ndhf_pkg::ID_W-1:0]    o_dropped_id,
    output logic [ndhf_pkg::SLOT_W-1:0]  o_slot
);
    import ndhf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;

    // Table storage: one synchronous memory, one read and one write port.
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_mem_q;

    logic [CW-1:0]      r_count;
    logic [LIMIT_W-1:0] r_limit;

    // Held copy of the item under search.
    logic [ID_W-1:0]   r_in_id;
    logic [FP_W-1:0]   r_in_fp;
    logic [SIZE_W-1:0] r_in_size;

    // Scan pipeline: read issue -> byte counts -> distance compare.
    logic [CW-1:0]   r_rd_addr;
    logic            r_s1_vld;
    logic [AW-1:0]   r_s1_idx;
    logic            r_s2_vld;
    logic [AW-1:0]   r_s2_idx;
    logic            r_s2_less;
    logic [ID_W-1:0] r_s2_id;
    logic [BC_W-1:0] r_s2_bc [BYTES];

    // First matching entry of the current scan.
    logic            r_hit;
    logic [AW-1:0]   r_hit_idx;
    logic            r_hit_less;
    logic [ID_W-1:0] r_hit_id;

    // Output register.
    logic              r_out_valid;
    t_outcome          r_outcome;
    logic [ID_W-1:0]   r_dropped_id;
    logic [SLOT_W-1:0] r_slot;

    logic [LIMIT_W-1:0] s2_dist;
    logic               s2_match;
    logic               can_issue;
    logic               rd_issue;
    logic               scan_end;
    logic               produce;
    logic [FP_W-1:0]    s1_diff;

    t_outcome          n_outcome;
    logic [ID_W-1:0]   n_dropped_id;
    logic [SLOT_W-1:0] n_slot;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              n_append;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_outcome    = r_outcome;
    assign o_dropped_id = r_dropped_id;
    assign o_slot       = r_slot;

    // Sum the per-byte counts into the Hamming distance (at most 64, fits 7 bits).
    always_comb begin
        s2_dist = '0;
        for (int b = 0; b < BYTES; b++) begin
            s2_dist = s2_dist + LIMIT_W'(r_s2_bc[b]);
        end
    end

    assign s2_match  = r_s2_vld && (s2_dist <= r_limit);
    assign can_issue = (r_rd_addr < r_count);
    assign rd_issue  = (r_state == S_SCAN) && can_issue && !s2_match;
    // Nothing left to read and nothing in flight that could still match.
    assign scan_end  = !can_issue && !r_s1_vld && !r_s2_vld;
    assign s1_diff   = r_in_fp ^ r_mem_q.hash;

    // Finish an item once the output register is free.
    assign produce = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_outcome    = OUT_FULL;
        n_dropped_id = '0;
        n_slot       = '0;
        wr_en        = 1'b0;
        wr_addr      = r_hit_idx;
        n_append     = 1'b0;
        if (r_hit) begin
            n_slot = to_slot(r_hit_idx);
            if (r_hit_less) begin
                // Input is the smaller file: drop it, leave the table alone.
                n_outcome    = OUT_DROPPED;
                n_dropped_id = r_in_id;
            end else begin
                // Stored entry loses (ties included): overwrite it in place.
                n_outcome    = OUT_REPLACED;
                n_dropped_id = r_hit_id;
                wr_en        = produce;
            end
        end else if (r_count < CW'(TABLE_ENTRIES)) begin
            n_outcome = OUT_STORED;
            wr_addr   = r_count[AW-1:0];
            n_slot    = to_slot(r_count[AW-1:0]);
            wr_en     = produce;
            n_append  = produce;
        end
    end

    // Table memory: registered read, single write.
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_mem_q <= r_mem[r_rd_addr[AW-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= '{id: r_in_id, hash: r_in_fp, size: r_in_size};
        end
    end

    // Pipeline payload (no reset needed).
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_id   <= i_item_id;
            r_in_fp   <= i_fingerprint;
            r_in_size <= i_file_size;
        end
        if (rd_issue) begin
            r_s1_idx <= r_rd_addr[AW-1:0];
        end
        if (r_s1_vld) begin
            r_s2_idx  <= r_s1_idx;
            r_s2_less <= (r_in_size < r_mem_q.size);
            r_s2_id   <= r_mem_q.id;
            for (int b = 0; b < BYTES; b++) begin
                r_s2_bc[b] <= byte_ones(s1_diff[8*b +: 8]);
            end
        end
        if (s2_match && (r_state == S_SCAN)) begin
            r_hit_idx  <= r_s2_idx;
            r_hit_less <= r_s2_less;
            r_hit_id   <= r_s2_id;
        end
    end

    // Control state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_rd_addr   <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_distance_limit;
            end
            // Load the output register as an item finishes; clear it once taken.
            if (produce) begin
                r_out_valid  <= 1'b1;
                r_outcome    <= n_outcome;
                r_dropped_id <= n_dropped_id;
                r_slot       <= n_slot;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rd_addr <= '0;
                        r_s1_vld  <= 1'b0;
                        r_s2_vld  <= 1'b0;
                        r_hit     <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_issue) begin
                        r_rd_addr <= r_rd_addr + CW'(1);
                    end
                    // Drop anything in flight behind the first match.
                    r_s1_vld <= rd_issue;
                    r_s2_vld <= r_s1_vld && !s2_match;
                    if (s2_match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (scan_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (produce) begin
                        if (n_append) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // Fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("fill count above table depth");

    // A match can only come from a filled entry.
    a_match_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_match && r_state == S_SCAN) |-> ({1'b0, r_s2_idx} < (AW+1)'(r_count)))
        else $error("match reported on an unfilled entry");

    // Appending a new entry advances the fill count by one.
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && n_outcome == OUT_STORED) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("store-new result without fill count advance");

    // No scan traffic outside a search.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> (!rd_issue && !s2_match))
        else $error("table read or match outside scan");
`endif

endmodule

### verif/tb_near_duplicate_hash_filter_top.sv
// Self-checking testbench for near_duplicate_hash_filter_top: directed and random
// items against a behavioral table model kept in a small scoreboard class.
// Depends on ndhf_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_near_duplicate_hash_filter_top;
    import ndhf_pkg::*;

    // Longest quiet stretch tolerated: a full-table scan plus the longest random
    // stalls on both sides, taken several times over.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 160;

    typedef struct {
        t_outcome          outcome;
        logic [ID_W-1:0]   dropped_id;
        logic [SLOT_W-1:0] slot;
    } t_verdict;

    // Mirror of the kept-item table; predicts one verdict per accepted item.
    class dedup_tracker;
        logic [FP_W-1:0]   kept_fp   [TABLE_ENTRIES];
        logic [ID_W-1:0]   kept_id   [TABLE_ENTRIES];
        logic [SIZE_W-1:0] kept_size [TABLE_ENTRIES];
        int unsigned       kept_count;
        logic [LIMIT_W-1:0] limit;
        t_verdict          pending_verdicts[$];
        int unsigned       faults;

        function new();
            kept_count = 0;
            limit      = LIMIT_RESET;
            faults     = 0;
        endfunction

        function void set_limit(input logic [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        function int unsigned pending();
            return pending_verdicts.size();
        endfunction

        // Search in insertion order, stop at the first entry within the limit.
        function void note_item(input logic [ID_W-1:0] id, input logic [FP_W-1:0] fp,
                                input logic [SIZE_W-1:0] size);
            t_verdict    v;
            int unsigned idx;
            bit          hit;
            idx = 0;
            hit = 1'b0;
            while (!hit && idx < kept_count) begin
                if ($countones(fp ^ kept_fp[idx]) <= int'(limit)) hit = 1'b1;
                else idx++;
            end
            if (hit) begin
                v.slot = idx[SLOT_W-1:0];
                if (size < kept_size[idx]) begin
                    v.outcome    = OUT_DROPPED;
                    v.dropped_id = id;
                end else begin
                    // Equal sizes land here too: the stored entry gives way.
                    v.outcome      = OUT_REPLACED;
                    v.dropped_id   = kept_id[idx];
                    kept_fp[idx]   = fp;
                    kept_id[idx]   = id;
                    kept_size[idx] = size;
                end
            end else if (kept_count < TABLE_ENTRIES) begin
                v.outcome             = OUT_STORED;
                v.dropped_id          = '0;
                v.slot                = kept_count[SLOT_W-1:0];
                kept_fp[kept_count]   = fp;
                kept_id[kept_count]   = id;
                kept_size[kept_count] = size;
                kept_count++;
            end else begin
                v.outcome    = OUT_FULL;
                v.dropped_id = '0;
                v.slot       = '0;
            end
            pending_verdicts.insert(pending_verdicts.size(), v);
        endfunction

        function void check_verdict(input logic [1:0] outcome,
                                    input logic [ID_W-1:0] dropped_id,
                                    input logic [SLOT_W-1:0] slot);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing expected: outcome %0d id %h slot %0d",
                         $time, outcome, dropped_id, slot);
                faults++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (outcome !== v.outcome) begin
                $display("%0t: outcome mismatch, expected %0d, actual %0d",
                         $time, v.outcome, outcome);
                faults++;
            end
            if (dropped_id !== v.dropped_id) begin
                $display("%0t: dropped_id mismatch, expected %h, actual %h",
                         $time, v.dropped_id, dropped_id);
                faults++;
            end
            if (slot !== v.slot) begin
                $display("%0t: slot mismatch, expected %0d, actual %0d",
                         $time, v.slot, slot);
                faults++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [LIMIT_W-1:0]  i_distance_limit;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ID_W-1:0]     i_item_id;
    logic [FP_W-1:0]     i_fingerprint;
    logic [SIZE_W-1:0]   i_file_size;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_outcome;
    logic [ID_W-1:0]     o_dropped_id;
    logic [SLOT_W-1:0]   o_slot;

    dedup_tracker        board;
    int unsigned         in_idle_pct;
    int unsigned         out_idle_pct;
    int unsigned         quiet_cycles;
    logic [LIMIT_W-1:0]  phase_limit [PHASES];

    near_duplicate_hash_filter_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_distance_limit (i_distance_limit),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_item_id        (i_item_id),
        .i_fingerprint    (i_fingerprint),
        .i_file_size      (i_file_size),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_dropped_id     (o_dropped_id),
        .o_slot           (o_slot)
    );

    // 8 ns period.
    always #4 i_clk = ~i_clk;

    // Receiver: drop ready at random for the share of cycles set per phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Check every result item taken at this edge against the oldest verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_verdict(o_outcome, o_dropped_id, o_slot);
        end
    end

    // Watchdog: any handshake clears the count; a long quiet stretch ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item; hold valid and payload until accepted. Valid is lowered only
    // during a sender gap or a drain, so back-to-back items keep it high.
    task automatic push_item(input logic [ID_W-1:0] id, input logic [FP_W-1:0] fp,
                             input logic [SIZE_W-1:0] size);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_item_id     <= id;
        i_fingerprint <= fp;
        i_file_size   <= size;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_item(id, fp, size);
    endtask

    // Stop offering items and wait for every predicted result to come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Write the distance limit; only called with the block idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_valid      <= 1'b1;
        i_distance_limit <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_limit(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly near copies of kept fingerprints (up to limit+2 random bit flips, up to 64
    // above limit 61) with sizes around the kept size; the rest is fresh or extreme.
    task automatic random_item();
        logic [FP_W-1:0]   fp;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   id;
        int unsigned       kind;
        int unsigned       pick;
        int unsigned       flips;
        int unsigned       flip_max;
        int unsigned       b;
        kind = $urandom_range(99);
        id   = ID_W'($urandom);
        fp   = {$urandom, $urandom};
        size = $urandom;
        if (board.kept_count != 0 && kind < 60) begin
            pick     = $urandom_range(board.kept_count - 1);
            fp       = board.kept_fp[pick];
            flip_max = (board.limit > 61) ? FP_W : int'(board.limit) + 2;
            flips    = $urandom_range(flip_max);
            repeat (flips) begin
                b     = $urandom_range(FP_W - 1);
                fp[b] = ~fp[b];
            end
            case ($urandom_range(3))
                0: size = board.kept_size[pick];
                1: size = board.kept_size[pick] + 1'b1;
                2: size = board.kept_size[pick] - 1'b1;
                default: ;
            endcase
        end else if (kind < 72) begin
            b = $urandom_range(FP_W - 1);
            case ($urandom_range(3))
                0: fp = '0;
                1: fp = '1;
                2: begin
                    fp    = '0;
                    fp[b] = 1'b1;
                end
                default: begin
                    fp    = '1;
                    fp[b] = 1'b0;
                end
            endcase
        end
        // Pull sizes to the ends of the range now and then.
        case ($urandom_range(19))
            0: size = '0;
            1: size = '1;
            default: ;
        endcase
        push_item(id, fp, size);
    endtask

    initial begin
        board            = new();
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_distance_limit = LIMIT_RESET;
        i_in_valid       = 1'b0;
        i_item_id        = '0;
        i_fingerprint    = '0;
        i_file_size      = '0;
        i_out_ready      = 1'b0;
        quiet_cycles     = 0;
        in_idle_pct      = 34;
        out_idle_pct     = 57;
        phase_limit      = '{7'd3, 7'd0, 7'd2, 7'd64, 7'd5, 7'd127,
                             7'd1, 7'd0, 7'd8, 7'd0, 7'd65, 7'd4};
        phase_limit[7]   = LIMIT_W'($urandom_range(6, 40));
        phase_limit[11]  = LIMIT_W'($urandom_range(127));

        // Hold reset, then release it for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limit of 3: appends, an equal-size replace, larger-size replaces and a
        // smaller input dropped.
        push_item(16'h0000, 64'h0, 32'h0);
        push_item(16'hFFFF, '1, '1);
        push_item(16'h0001, 64'h7, 32'h0);
        push_item(16'h0002, 64'h0F00_0000_0000_0000, 32'h5);
        push_item(16'h0003, ~64'h7, 32'hFFFF_FFFE);
        push_item(16'h0004, 64'h0F00_0000_0000_0001, '1);
        push_item(16'h0005, 64'hF, 32'h1);
        push_item(16'h0006, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000);
        push_item(16'h0007, 64'h5555_5555_5555_5555, 32'h0);

        // Limit 0: only exact copies match.
        drain();
        write_limit(7'd0);
        push_item(16'h0008, 64'hAAAA_AAAA_AAAA_AAAB, 32'h1234_5678);
        push_item(16'h0009, 64'hAAAA_AAAA_AAAA_AAAA, 32'h7FFF_FFFF);
        push_item(16'h000A, 64'h5555_5555_5555_5555, 32'h0);

        // Limit 64 and above: every item meets slot 0 first.
        drain();
        write_limit(7'd64);
        push_item(16'h000B, 64'hFFFF_FFFF_FFFF_FFF0, 32'h0);
        push_item(16'h000C, '1, '1);
        drain();
        write_limit(7'd127);
        push_item(16'h000D, 64'h0, 32'h0);
        push_item(16'hFFFE, 64'h0123_4567_89AB_CDEF, '1);

        // Random phases; the table fills early on, so later phases also see
        // full-table rejects and matches deep in the table.
        for (int p = 0; p < PHASES; p++) begin
            if (p < PHASES / 3) begin
                in_idle_pct  = 34;
                out_idle_pct = 57;
            end else if (p < 2 * PHASES / 3) begin
                in_idle_pct  = 57;
                out_idle_pct = 34;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            drain();
            write_limit(phase_limit[p]);
            repeat (PHASE_ITEMS) random_item();
        end

        // Let the last results settle, then give the verdict.
        drain();
        repeat (16) @(posedge i_clk);
        if (board.faults == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### near_duplicate_hash_filter_top.f
hw/rtl/ndhf_pkg.sv
hw/rtl/near_duplicate_hash_filter_top.sv
verif/tb_near_duplicate_hash_filter_top.sv
